### rtl/ksc_pkg.sv
package ksc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int IDX_W         = $clog2(ALPHABET_SIZE);
  localparam int FILL_W        = $clog2(ALPHABET_SIZE + 1);

  localparam logic [IDX_W-1:0]  LAST_LETTER = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(ALPHABET_SIZE);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LETTER = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_TEXT   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] letter;
  } place_t;

endpackage

### rtl/keyword_substitution_cipher_core.sv
// Keyword substitution cipher.
// Input stream: in_tuser carries the command (clear key, keyword letter,
// finish key, text byte), in_tdata the character. Only text bytes give a
// result on the output stream: out_tdata is the substituted upper-case
// letter or the byte unchanged, out_tuser[0] flags a missing key.
// cfg_wen/cfg_wdata write decrypt mode; write it only while idle.
// Clear, keyword letter and non-letter or keyless text bytes are done
// with their transfer; a text letter reads the forward or inverse table
// memory into a read register, then a lookup state loads the output
// register once the output slot is free, no transfer being taken before.
// Finishing the key walks the alphabet Z to A, one letter a cycle, holding
// off inputs until the walk ends (none when the key is already full).
// Both tables are written together as letters are placed, so the inverse
// table needs no pass of its own.
// Reset clears the used-letter flags, fill count, key-ready flag, mode and
// the output valid flag; the table memories are not cleared.
// A held result stalls text transfers only; other commands still flow.
module keyword_substitution_cipher_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wen,
  input  logic [0:0] cfg_wdata,   // decrypt_mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // value
  input  logic [1:0] in_tuser,    // command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // out_byte
  output logic [0:0] out_tuser    // key_missing
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_LOOKUP
  } state_t;

  localparam int IW = ksc_pkg::IDX_W;
  localparam int FW = ksc_pkg::FILL_W;

  state_t                          state_r, state_nxt;
  logic [ksc_pkg::ALPHABET_SIZE-1:0] used_r, used_nxt;
  logic [FW-1:0]                   fill_r, fill_nxt;
  logic                            key_ready_r, key_ready_nxt;
  logic [IW-1:0]                   walk_r, walk_nxt;
  logic                            mode_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_byte_r, out_byte_nxt;
  logic                            out_miss_r, out_miss_nxt;

  logic [IW-1:0] fwd_mem [ksc_pkg::ALPHABET_SIZE];
  logic [IW-1:0] inv_mem [ksc_pkg::ALPHABET_SIZE];
  logic [IW-1:0] fwd_rd_r, inv_rd_r;

  ksc_pkg::cmd_t   cmd;
  logic            is_upper, is_lower, is_letter;
  logic [IW-1:0]   idx;
  logic            accept;
  logic            slot_free;
  logic            rd_en;
  ksc_pkg::place_t place;
  logic [IW-1:0]   mapped;

  assign cmd       = ksc_pkg::cmd_t'(in_tuser);
  assign is_upper  = (in_tdata >= ksc_pkg::CHAR_UPPER_A) && (in_tdata <= ksc_pkg::CHAR_UPPER_Z);
  assign is_lower  = (in_tdata >= ksc_pkg::CHAR_LOWER_A) && (in_tdata <= ksc_pkg::CHAR_LOWER_Z);
  assign is_letter = is_upper || is_lower;
  assign idx       = is_upper ? IW'(in_tdata - ksc_pkg::CHAR_UPPER_A)
                              : IW'(in_tdata - ksc_pkg::CHAR_LOWER_A);

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && (slot_free || (cmd != ksc_pkg::CMD_TEXT));
  assign accept    = in_tvalid && in_tready;
  assign rd_en     = accept && (cmd == ksc_pkg::CMD_TEXT) && key_ready_r && is_letter;
  assign mapped    = mode_r ? inv_rd_r : fwd_rd_r;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tuser[0] = out_miss_r;

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    key_ready_nxt = key_ready_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_miss_nxt  = out_miss_r;
    place.en      = 1'b0;
    place.letter  = idx;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            ksc_pkg::CMD_CLEAR: begin
              used_nxt      = '0;
              fill_nxt      = '0;
              key_ready_nxt = 1'b0;
            end
            ksc_pkg::CMD_LETTER: begin
              if (!key_ready_r && is_letter && (fill_r < ksc_pkg::FILL_FULL) && !used_r[idx]) begin
                place.en = 1'b1;
              end
            end
            ksc_pkg::CMD_FINISH: begin
              if (fill_r < ksc_pkg::FILL_FULL) begin
                walk_nxt  = ksc_pkg::LAST_LETTER;
                state_nxt = ST_FINISH;
              end else begin
                key_ready_nxt = 1'b1;
              end
            end
            ksc_pkg::CMD_TEXT: begin
              if (rd_en) begin
                state_nxt = ST_LOOKUP;
              end else begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = in_tdata;
                out_miss_nxt  = !key_ready_r;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FINISH: begin
        place.letter = walk_r;
        place.en     = (fill_r < ksc_pkg::FILL_FULL) && !used_r[walk_r];
        walk_nxt     = walk_r - IW'(1);
        if (walk_r == '0) begin
          key_ready_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = ksc_pkg::CHAR_UPPER_A + 8'(mapped);
          out_miss_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (place.en) begin
      used_nxt[place.letter] = 1'b1;
      fill_nxt               = fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      key_ready_r <= 1'b0;
      walk_r      <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      key_ready_r <= key_ready_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        mode_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_miss_r <= out_miss_nxt;
  end

  // both tables written at once; forward at fill position, inverse at the letter
  always_ff @(posedge clk) begin
    if (place.en) begin
      fwd_mem[IW'(fill_r)]  <= place.letter;
      inv_mem[place.letter] <= IW'(fill_r);
    end
    if (rd_en) begin
      fwd_rd_r <= fwd_mem[idx];
      inv_rd_r <= inv_mem[idx];
    end
  end

endmodule
